>>> design/four_channel_servo_slew_ramp_assert.svh
// Assertion macros for the servo slew ramp block.
// Used by modules that check their own state; needs clk and rst_n in scope.
`ifndef FOUR_CHANNEL_SERVO_SLEW_RAMP_ASSERT_SVH
`define FOUR_CHANNEL_SERVO_SLEW_RAMP_ASSERT_SVH

// Same-cycle implication, off while in reset.
`define FCSSR_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define FCSSR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/fcssr_pkg.sv
// Shared types and constants for the four-channel servo slew ramp.
// No dependencies.
`default_nettype none

package fcssr_pkg;

  localparam int unsigned NUM_SLOTS = 4;
  // Channels at this index and above are never stepped or loaded.
  localparam int unsigned CHANNELS  = 4;

  localparam logic [15:0] BASE_RESET = 16'd1760;
  localparam logic [7:0]  GAIN_RESET = 8'd33;

  // Power-up widths: base + gain * {43, 45, 28, 45}.
  localparam logic [15:0] RESET_WIDTH [NUM_SLOTS] = '{
    16'(32'd1760 + 32'd43 * 32'd33),
    16'(32'd1760 + 32'd45 * 32'd33),
    16'(32'd1760 + 32'd28 * 32'd33),
    16'(32'd1760 + 32'd45 * 32'd33)
  };

  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_DEG  = 2'd1,
    MODE_RAW  = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [0:0] {
    REG_PULSE_BASE       = 1'b0,
    REG_PULSE_PER_DEGREE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] target_0;
    logic [15:0] target_1;
    logic [15:0] target_2;
    logic [15:0] target_3;
  } in_item_t;

  typedef struct packed {
    logic [15:0] duty_0;
    logic [15:0] duty_1;
    logic [15:0] duty_2;
    logic [15:0] duty_3;
    logic [15:0] goal_0;
    logic [15:0] goal_1;
    logic [15:0] goal_2;
    logic [15:0] goal_3;
    logic        moving;
  } out_item_t;

  // What one lane reports for the item being accepted.
  typedef struct packed {
    logic [15:0] duty;
    logic [15:0] goal;
    logic        differs;
  } lane_stat_t;

endpackage

`default_nettype wire

>>> design/four_channel_servo_slew_ramp.sv
// Four-channel servo slew ramp, one item per clock with a registered result
// beat. The result of each item appears in the cycle after it is accepted; a new
// beat is taken in every cycle in which the held result is either absent or
// being taken, so the rate is one item per cycle, set by the single lane update
// stage and the output register. Each tick moves every active channel one unit
// toward its target; degree loads use base + degrees * gain, saturating at
// 65535. Registers: index 0 pulse_base, index 1 pulse_per_degree.
// Depends on fcssr_pkg, fcssr_lane and fcssr_merge.
`default_nettype none

module four_channel_servo_slew_ramp (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire fcssr_pkg::in_item_t   in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output fcssr_pkg::out_item_t       out_data,
  input  wire logic                  cfg_we,
  input  wire logic [0:0]            cfg_index,
  input  wire logic [15:0]           cfg_wdata
);
  import fcssr_pkg::*;

  logic        accept;
  logic [15:0] base_r;
  logic [7:0]  gain_r;
  logic [15:0] tgt_field [NUM_SLOTS];
  lane_stat_t [NUM_SLOTS-1:0] lane_stat;

  // Held beat not taken this cycle blocks the input.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
      gain_r <= GAIN_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_PULSE_BASE:       base_r <= cfg_wdata;
        REG_PULSE_PER_DEGREE: gain_r <= cfg_wdata[7:0];
        default:              ;
      endcase
    end
  end

  assign tgt_field[0] = in_data.target_0;
  assign tgt_field[1] = in_data.target_1;
  assign tgt_field[2] = in_data.target_2;
  assign tgt_field[3] = in_data.target_3;

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_lane
    fcssr_lane u_lane (
      .clk              (clk),
      .rst_n            (rst_n),
      .active           (g < CHANNELS),
      .reset_width      (RESET_WIDTH[g]),
      .accept           (accept),
      .mode             (in_data.mode),
      .target_in        (tgt_field[g]),
      .pulse_base       (base_r),
      .pulse_per_degree (gain_r),
      .stat             (lane_stat[g])
    );
  end

  fcssr_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .lanes     (lane_stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> design/fcssr_lane.sv
// One servo channel: current and target width, slew step and target load.
// Depends on fcssr_pkg and four_channel_servo_slew_ramp_assert.svh.
`default_nettype none

`include "four_channel_servo_slew_ramp_assert.svh"

module fcssr_lane (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    active,
  input  wire logic [15:0]             reset_width,
  input  wire logic                    accept,
  input  wire logic [1:0]              mode,
  input  wire logic [15:0]             target_in,
  input  wire logic [15:0]             pulse_base,
  input  wire logic [7:0]              pulse_per_degree,
  output fcssr_pkg::lane_stat_t        stat
);
  import fcssr_pkg::*;

  logic [15:0] cur_r, cur_nxt;
  logic [15:0] tgt_r, tgt_nxt;
  logic [15:0] prod;
  logic [16:0] deg_sum;
  logic [15:0] deg_width;

  // 8x8 product plus base; a carry out means saturate.
  assign prod      = 16'(target_in[7:0]) * 16'(pulse_per_degree);
  assign deg_sum   = {1'b0, pulse_base} + {1'b0, prod};
  assign deg_width = deg_sum[16] ? 16'hFFFF : deg_sum[15:0];

  always_comb begin
    cur_nxt = cur_r;
    tgt_nxt = tgt_r;
    if (active) begin
      case (mode_t'(mode))
        MODE_TICK: begin
          if (cur_r < tgt_r) begin
            cur_nxt = cur_r + 16'd1;
          end else if (cur_r > tgt_r) begin
            cur_nxt = cur_r - 16'd1;
          end
        end
        MODE_DEG:  tgt_nxt = deg_width;
        MODE_RAW:  tgt_nxt = target_in;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= reset_width;
      tgt_r <= reset_width;
    end else if (accept) begin
      cur_r <= cur_nxt;
      tgt_r <= tgt_nxt;
    end
  end

  assign stat.duty    = cur_nxt;
  assign stat.goal    = tgt_nxt;
  assign stat.differs = active && (cur_nxt != tgt_nxt);

  `FCSSR_ASSERT(a_idle_lane_fixed, !active, (cur_r == reset_width) && (tgt_r == reset_width), "inactive lane left reset")
  `FCSSR_ASSERT_NXT(a_load_holds_cur, rst_n && accept && (mode != MODE_TICK), $stable(cur_r), "load moved current width")
  `FCSSR_ASSERT_NXT(a_tick_holds_tgt, rst_n && accept && (mode == MODE_TICK), $stable(tgt_r), "tick changed target")
  `FCSSR_ASSERT_NXT(a_tick_one_step, rst_n && accept && (mode == MODE_TICK), (cur_r == $past(cur_r)) || (cur_r == $past(cur_r) + 16'd1) || (cur_r == $past(cur_r) - 16'd1), "slew step larger than one")

endmodule

`default_nettype wire

>>> design/fcssr_merge.sv
// Merge stage: packs lane results into the output beat and ORs the moving flags.
// Depends on fcssr_pkg.
`default_nettype none

module fcssr_merge (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire logic                                        accept,
  input  wire fcssr_pkg::lane_stat_t [fcssr_pkg::NUM_SLOTS-1:0] lanes,
  input  wire logic                                        out_stall,
  output logic                                             out_valid,
  output fcssr_pkg::out_item_t                             out_data
);
  import fcssr_pkg::*;

  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t beat_nxt;
  logic      any_moving;

  always_comb begin
    any_moving = 1'b0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      any_moving = any_moving | lanes[k].differs;
    end
    beat_nxt.duty_0 = lanes[0].duty;
    beat_nxt.duty_1 = lanes[1].duty;
    beat_nxt.duty_2 = lanes[2].duty;
    beat_nxt.duty_3 = lanes[3].duty;
    beat_nxt.goal_0 = lanes[0].goal;
    beat_nxt.goal_1 = lanes[1].goal;
    beat_nxt.goal_2 = lanes[2].goal;
    beat_nxt.goal_3 = lanes[3].goal;
    beat_nxt.moving = any_moving;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= beat_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
